@@ rtl/core/three_level_priority_slot_buffer_macros.svh @@
// Assertion macros for the three-level priority slot buffer checker.
`ifndef THREE_LEVEL_PRIORITY_SLOT_BUFFER_MACROS_SVH
`define THREE_LEVEL_PRIORITY_SLOT_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TLPSB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlpsb assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TLPSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlpsb assertion failed");

`endif

@@ rtl/core/tlpsb_pkg.sv @@
// Package: types, constants and codes of the three-level priority slot buffer.
`timescale 1ns / 1ps
package tlpsb_pkg;

  localparam int DEPTH   = 16;
  localparam int VALUE_W = 16;
  localparam int SLOT_W  = $clog2(DEPTH);
  localparam int PRIO_W  = 2;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [PRIO_W-1:0] PRIO_NONE = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_MID  = 2'd2;
  localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd3;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic                cmd;
    logic [VALUE_W-1:0]  new_value;
    logic [PRIO_W-1:0]   new_priority;
  } req_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  out_value;
    logic [PRIO_W-1:0]   out_priority;
    logic [SLOT_W-1:0]   slot;
    status_t             status;
    logic                is_full;
    logic                has_items;
  } rsp_t;

endpackage

@@ rtl/core/tlpsb_find.sv @@
// Rotated find-first: lowest set bit at or after start, else lowest set bit.
`timescale 1ns / 1ps
module tlpsb_find
  import tlpsb_pkg::*;
(
  input  logic [DEPTH-1:0]  vec,
  input  logic [SLOT_W-1:0] start,
  output logic              hit,
  output logic [SLOT_W-1:0] idx
);

  logic              hi_hit;
  logic [SLOT_W-1:0] hi_idx;
  logic              lo_hit;
  logic [SLOT_W-1:0] lo_idx;

  always_comb begin
    hi_hit = 1'b0;
    hi_idx = '0;
    lo_hit = 1'b0;
    lo_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (vec[i]) begin
        lo_hit = 1'b1;
        lo_idx = SLOT_W'(i);
        if (SLOT_W'(i) >= start) begin
          hi_hit = 1'b1;
          hi_idx = SLOT_W'(i);
        end
      end
    end
    hit = lo_hit;
    idx = hi_hit ? hi_idx : lo_idx;
  end

endmodule

@@ rtl/core/tlpsb_core.sv @@
// Slot store, start pointer and the combinational insert/remove step.
`timescale 1ns / 1ps
module tlpsb_core
  import tlpsb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  output rsp_t rsp
);

  logic [VALUE_W-1:0] value_mem [DEPTH];
  logic [PRIO_W-1:0]  prio_mem  [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic [DEPTH-1:0]   valid_next;
  logic [SLOT_W-1:0]  start_ptr;
  logic [SLOT_W-1:0]  start_ptr_next;

  logic [DEPTH-1:0]   m1;
  logic [DEPTH-1:0]   m2;
  logic [DEPTH-1:0]   m3;
  logic [DEPTH-1:0]   rm_vec;
  logic [PRIO_W-1:0]  rm_level;
  logic [PRIO_W-1:0]  prio_in;

  logic               free_hit;
  logic [SLOT_W-1:0]  free_idx;
  logic               rm_hit;
  logic [SLOT_W-1:0]  rm_idx;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      m1[i] = valid[i] && (prio_mem[i] == PRIO_HIGH);
      m2[i] = valid[i] && (prio_mem[i] == PRIO_MID);
      m3[i] = valid[i] && (prio_mem[i] == PRIO_LOW);
    end
    if (|m1) begin
      rm_vec   = m1;
      rm_level = PRIO_HIGH;
    end else if (|m2) begin
      rm_vec   = m2;
      rm_level = PRIO_MID;
    end else begin
      rm_vec   = m3;
      rm_level = PRIO_LOW;
    end
  end

  tlpsb_find u_find_free (
    .vec   (~valid),
    .start (start_ptr),
    .hit   (free_hit),
    .idx   (free_idx)
  );

  tlpsb_find u_find_rm (
    .vec   (rm_vec),
    .start (start_ptr),
    .hit   (rm_hit),
    .idx   (rm_idx)
  );

  // priority 0 is kept as the lowest level
  assign prio_in = (req.new_priority == PRIO_NONE) ? PRIO_LOW : req.new_priority;

  always_comb begin
    valid_next       = valid;
    start_ptr_next   = start_ptr;
    rsp.out_value    = '0;
    rsp.out_priority = PRIO_NONE;
    rsp.slot         = '0;
    rsp.status       = ST_DONE;
    if (req.cmd == CMD_INSERT) begin
      if (free_hit) begin
        valid_next[free_idx] = 1'b1;
        rsp.slot             = free_idx;
      end else begin
        rsp.status = ST_FULL;
      end
    end else begin
      if (rm_hit) begin
        valid_next[rm_idx] = 1'b0;
        rsp.out_value      = value_mem[rm_idx];
        rsp.out_priority   = rm_level;
        rsp.slot           = rm_idx;
        start_ptr_next     = (rm_idx == LAST_SLOT) ? '0 : rm_idx + 1'b1;
      end else begin
        rsp.status = ST_EMPTY;
      end
    end
    rsp.is_full   = &valid_next;
    rsp.has_items = |valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      start_ptr <= '0;
    end else if (step) begin
      valid     <= valid_next;
      start_ptr <= start_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && (req.cmd == CMD_INSERT) && free_hit) begin
      value_mem[free_idx] <= req.new_value;
      prio_mem[free_idx]  <= prio_in;
    end
  end

endmodule

@@ rtl/core/three_level_priority_slot_buffer.sv @@
// Top level of the three-level priority slot buffer: request and result registers.
//
//   channel   valid      ready      payload    direction
//   request   req_valid  req_ready  req_data   in
//   result    res_valid  res_ready  res_data   out
//
// One request per cycle while the result register drains. A request enters the request
// register at acceptance; the slot search and update then load the result register, from
// which the result is taken.
// The store updates as a request moves to the result register, so back-to-back
// requests see each other's effect. Synchronous rst clears all valid bits and the
// start pointer; there is no clearing pass. A stalled result holds the chain.
`timescale 1ns / 1ps
module three_level_priority_slot_buffer
  import tlpsb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic res_valid,
  input  logic res_ready,
  output rsp_t res_data
);

  req_t req_q;
  logic req_full;
  rsp_t res_q;
  logic res_full;
  rsp_t rsp;
  logic advance;

  assign advance   = req_full && (!res_full || res_ready);
  assign req_ready = !req_full || advance;
  assign res_valid = res_full;
  assign res_data  = res_q;

  tlpsb_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_q),
    .rsp  (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      res_full <= 1'b0;
    end else begin
      if (req_ready) begin
        req_full <= req_valid;
      end
      if (advance) begin
        res_full <= 1'b1;
      end else if (res_ready) begin
        res_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req_data;
    end
    if (advance) begin
      res_q <= rsp;
    end
  end

endmodule

@@ rtl/core/tlpsb_checker.sv @@
// Port-level checker for the three-level priority slot buffer, with its bind.
`timescale 1ns / 1ps
`include "three_level_priority_slot_buffer_macros.svh"
module tlpsb_checker
  import tlpsb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req_data,
  input logic res_valid,
  input logic res_ready,
  input rsp_t res_data
);

  `TLPSB_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid)

  `TLPSB_ASSERT_IMP(a_empty_result, res_valid && (res_data.status == ST_EMPTY), (res_data.out_value == '0) && (res_data.out_priority == PRIO_NONE) && (res_data.slot == '0) && !res_data.has_items)

  `TLPSB_ASSERT_IMP(a_full_result, res_valid && (res_data.status == ST_FULL), res_data.is_full && res_data.has_items && (res_data.out_priority == PRIO_NONE))

  `TLPSB_ASSERT_IMP(a_full_has_items, res_valid && res_data.is_full, res_data.has_items)

  `TLPSB_ASSERT_IMP(a_removed_done, res_valid && (res_data.out_priority != PRIO_NONE), res_data.status == ST_DONE)

endmodule

bind three_level_priority_slot_buffer tlpsb_checker u_checker (.*);

@@ sim/slot_buffer_watch.sv @@
// Request/result monitor for the priority slot buffer: predicts each result and compares it.
`timescale 1ns / 1ps
module slot_buffer_watch
  import tlpsb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic res_valid,
  input  logic res_ready,
  input  rsp_t res_data,
  output int   mismatches,
  output int   outstanding,
  output int   checked,
  output int   full_drops,
  output int   empty_misses
);

  logic [VALUE_W-1:0] held_value [DEPTH];
  logic [PRIO_W-1:0]  held_prio  [DEPTH];
  logic               held_valid [DEPTH];
  int                 start_ptr;
  rsp_t               pending_results [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    checked      = 0;
    full_drops   = 0;
    empty_misses = 0;
    start_ptr    = 0;
    foreach (held_valid[i]) held_valid[i] = 1'b0;
  end

  function automatic rsp_t serve_request(input req_t r);
    rsp_t              res;
    logic [PRIO_W-1:0] p;
    logic              full;
    logic              any;
    bit                hit;
    int                idx;
    res = '0;
    hit = 1'b0;
    p   = (r.new_priority == PRIO_NONE) ? PRIO_LOW : r.new_priority;
    if (r.cmd == CMD_INSERT) begin
      res.status = ST_FULL;
      for (int k = 0; k < DEPTH && !hit; k++) begin
        idx = (start_ptr + k) % DEPTH;
        if (!held_valid[idx]) begin
          held_value[idx] = r.new_value;
          held_prio[idx]  = p;
          held_valid[idx] = 1'b1;
          res.slot        = SLOT_W'(idx);
          res.status      = ST_DONE;
          hit             = 1'b1;
        end
      end
    end else begin
      res.status = ST_EMPTY;
      for (int lvl = int'(PRIO_HIGH); lvl <= int'(PRIO_LOW) && !hit; lvl++) begin
        for (int k = 0; k < DEPTH && !hit; k++) begin
          idx = (start_ptr + k) % DEPTH;
          if (held_valid[idx] && held_prio[idx] == PRIO_W'(lvl)) begin
            res.out_value    = held_value[idx];
            res.out_priority = held_prio[idx];
            res.slot         = SLOT_W'(idx);
            res.status       = ST_DONE;
            held_valid[idx]  = 1'b0;
            start_ptr        = (idx + 1) % DEPTH;
            hit              = 1'b1;
          end
        end
      end
    end
    full = 1'b1;
    any  = 1'b0;
    foreach (held_valid[i]) begin
      if (held_valid[i]) any = 1'b1;
      else full = 1'b0;
    end
    res.is_full   = full;
    res.has_items = any;
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      foreach (held_valid[i]) held_valid[i] = 1'b0;
      start_ptr = 0;
      pending_results.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: %h", res_data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_value",    want.out_value,    res_data.out_value);
          check_field("out_priority", want.out_priority, res_data.out_priority);
          check_field("slot",         want.slot,         res_data.slot);
          check_field("status",       want.status,       res_data.status);
          check_field("is_full",      want.is_full,      res_data.is_full);
          check_field("has_items",    want.has_items,    res_data.has_items);
          checked++;
        end
      end
      if (req_valid && req_ready) begin
        want = serve_request(req_data);
        if (want.status == ST_FULL) full_drops++;
        if (want.status == ST_EMPTY) empty_misses++;
        pending_results.push_back(want);
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ sim/tb.sv @@
// Testbench top for the priority slot buffer: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps
module tb
  import tlpsb_pkg::*;
();

  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 100000;

  typedef enum {RX_FREE, RX_ALTERNATE, RX_MOSTLY, RX_SPARSE} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req_data;
  logic res_valid;
  logic res_ready;
  rsp_t res_data;

  int mismatches;
  int outstanding;
  int checked;
  int full_drops;
  int empty_misses;

  int          n_insert = 0;
  int          n_remove = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int unsigned cycle_count = 0;

  three_level_priority_slot_buffer uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  slot_buffer_watch watch (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req_data     (req_data),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res_data     (res_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .checked      (checked),
    .full_drops   (full_drops),
    .empty_misses (empty_misses)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("FAIL");
      $finish;
    end
  end

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_req(input logic c, input logic [VALUE_W-1:0] v,
                          input logic [PRIO_W-1:0] p);
    req_t r;
    r.cmd          = c;
    r.new_value    = v;
    r.new_priority = p;
    req_valid <= 1'b1;
    req_data  <= r;
    do @(posedge clk); while (!req_ready);
    if (c == CMD_INSERT) n_insert++;
    else n_remove++;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    req_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Receiver: long hold-offs on request, otherwise a randomly chosen stall pattern.
  initial begin
    rx_mode_t rx_mode;
    int       rx_tick;
    rx_mode   = RX_FREE;
    rx_tick   = 0;
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done < holds_asked) begin
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      rx_tick++;
      if (rx_tick % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE:      res_ready <= 1'b1;
        RX_ALTERNATE: res_ready <= (rx_tick % 2 == 0);
        RX_MOSTLY:    res_ready <= ($urandom_range(99) < 70);
        default:      res_ready <= ($urandom_range(99) < 25);
      endcase
    end
  end

  initial begin
    int                 sent;
    int                 burst;
    int                 ins_pct;
    bit                 midway_done;
    logic               c;
    logic [VALUE_W-1:0] v;
    logic [PRIO_W-1:0]  p;
    req_valid   = 1'b0;
    req_data    = '0;
    rst         = 1'b1;
    sent        = 0;
    midway_done = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty remove, value extremes, priority zero, fill, overflow, removes
    send_req(CMD_REMOVE, 16'h1111, PRIO_HIGH);
    send_req(CMD_INSERT, 16'h0000, PRIO_HIGH);
    send_req(CMD_INSERT, 16'hFFFF, PRIO_LOW);
    send_req(CMD_INSERT, 16'h1234, PRIO_NONE);
    send_req(CMD_INSERT, 16'h8001, PRIO_MID);
    for (int i = 0; i < DEPTH - 4; i++)
      send_req(CMD_INSERT, VALUE_W'($urandom_range(0, 65535)),
               PRIO_W'($urandom_range(PRIO_HIGH, PRIO_LOW)));
    send_req(CMD_INSERT, 16'hDEAD, PRIO_HIGH);
    repeat (5) send_req(CMD_REMOVE, VALUE_W'($urandom_range(0, 65535)), PRIO_NONE);
    wait_drained();

    holds_asked = 1;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0:       ins_pct = 15;
        1:       ins_pct = 50;
        default: ins_pct = 85;
      endcase
      repeat (burst) begin
        c = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_REMOVE;
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = '1;
          default: v = VALUE_W'($urandom_range(0, 65535));
        endcase
        p = PRIO_W'($urandom_range(0, 3));
        send_req(c, v, p);
        sent++;
      end
      if (!midway_done && sent >= RANDOM_ITEMS / 2) begin
        midway_done = 1'b1;
        wait_drained();
        holds_asked = 2;
      end else if ($urandom_range(3) != 0) begin
        pause_sender($urandom_range(1, 6));
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    $display("Sent %0d requests (%0d inserts, %0d removes); %0d results compared",
             n_insert + n_remove, n_insert, n_remove, checked);
    $display("Inserts dropped on a full buffer: %0d; removes from an empty one: %0d",
             full_drops, empty_misses);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/tlpsb_pkg.sv
rtl/core/tlpsb_find.sv
rtl/core/tlpsb_core.sv
rtl/core/three_level_priority_slot_buffer.sv
rtl/core/tlpsb_checker.sv
sim/slot_buffer_watch.sv
sim/tb.sv
